/* src/bgt_pkg.sv */
// bgt_pkg: shared types and constants of the bilinear grid table
// no dependencies
package bgt_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_LOAD_X    = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y    = 2'd1;
    localparam logic [1:0] CMD_LOAD_GRID = 2'd2;
    localparam logic [1:0] CMD_QUERY     = 2'd3;

    // configuration register indexes
    localparam logic CFG_X_POINTS = 1'b0;
    localparam logic CFG_Y_POINTS = 1'b1;

    localparam int          CFG_WIDTH  = 7;
    localparam int          WGT_WIDTH  = 17;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;
    localparam int          WGT_FRAC   = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        load_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_bgt_in;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [5:0]         x_cell;
        logic [5:0]         y_cell;
        logic               flat_interval;
    } t_bgt_out;

    // status of one axis search
    typedef struct packed {
        logic        done;
        logic        flat;
        logic [16:0] weight;
    } t_bgt_axis_stat;

endpackage

/* src/bgt_stream_if.sv */
// bgt_stream_if: valid/ready channel carrying one payload per transfer
// payload type given by parameter, normally from bgt_pkg
interface bgt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/bilinear_interp_grid_table.sv */
// bilinear_interp_grid_table: top level of the bilinear grid table
// uses bgt_pkg, bgt_stream_if, bgt_ram and bgt_axis
//
// i_in takes one item per transfer: a load of an x breakpoint, a y
// breakpoint or a grid value, or a query. loads are written in the
// cycle of their transfer and give no result. a query gives one result
// transfer on o_out: the blended Q16.16 value, the chosen cell on each
// axis and a flag for a zero-width interval.
// the x and y searches run side by side, each with its own breakpoint
// ram: two reads for the end points, one read per bisection step
// (log2 of the points in use less one, rounded up), two reads for the
// cell bounds and, inside the cell, a restoring division for the 16-bit
// quotient. the four grid corners then pass in turn through T_RD, T_MUL
// and T_ACC, sharing the read port of the grid ram.
// the corners begin once the slower axis search is done; a weight that
// needs no division skips the division. the next item can be taken in
// the cycle after the result is written.
// i_in is ready only while no query is in work. a finished result waits
// in the output register while the receiver stalls; the next item may
// still be taken, and a following query holds at its last step until
// the register is free.
// the configuration port writes x_points and y_points (clamped to 2..max);
// the user must write them only while idle, which the block leaves unchecked.
// reset (synchronous, active low) sets both point counts to 2 and empties
// the output register. ram contents stay undefined until loaded.
module bilinear_interp_grid_table #(
    parameter int MAX_X_POINTS = 64,
    parameter int MAX_Y_POINTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bgt_stream_if.sink                i_in,
    bgt_stream_if.source              o_out,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bgt_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    localparam int XW   = $clog2(MAX_X_POINTS);
    localparam int YW   = $clog2(MAX_Y_POINTS);
    localparam int XPW  = $clog2(MAX_X_POINTS + 1);
    localparam int YPW  = $clog2(MAX_Y_POINTS + 1);
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GW   = $clog2(GRID_DEPTH);
    localparam int PW   = VALUE_WIDTH + 34;   // weight times value
    localparam int SW   = VALUE_WIDTH + 36;   // accumulator
    localparam int RW   = SW - 32;            // after the 2^32 scaling

    typedef enum logic [2:0] {
        T_IDLE, T_AXIS, T_BASE, T_RD, T_MUL, T_ACC, T_FIN
    } t_tstate;

    t_tstate                 r_state;
    logic [XPW-1:0]          r_x_points;
    logic [YPW-1:0]          r_y_points;
    logic [GW-1:0]           r_base;
    logic [1:0]              r_corner;
    logic [32:0]             r_w;
    logic signed [PW-1:0]    r_prod;
    logic signed [SW-1:0]    r_sum;
    logic                    r_out_valid;
    bgt_pkg::t_bgt_out       r_out;

    logic                    in_xfer, out_xfer, is_query;
    logic [XW-1:0]           x_cell;
    logic [YW-1:0]           y_cell;
    bgt_pkg::t_bgt_axis_stat x_stat, y_stat;
    logic [VALUE_WIDTH-1:0]  load_val;
    logic [GW-1:0]           g_raddr;
    logic signed [VALUE_WIDTH-1:0] g_rdata;
    logic [16:0]             ta, tb;
    logic signed [RW-1:0]    res;
    logic signed [VALUE_WIDTH-1:0] sat;
    logic                    fits;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign is_query = (i_in.data.cmd == bgt_pkg::CMD_QUERY);
    assign i_in.ready = (r_state == T_IDLE);

    // load value as stored: low bits, zero above the 32 input bits
    assign load_val = VALUE_WIDTH'({32'd0, i_in.data.load_value});

    bgt_axis #(.DEPTH(MAX_X_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_x_axis (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (in_xfer && i_in.data.cmd == bgt_pkg::CMD_LOAD_X &&
                   32'(i_in.data.load_index) < MAX_X_POINTS),
        .i_waddr  (XW'(i_in.data.load_index)),
        .i_wdata  (load_val),
        .i_start  (in_xfer && is_query),
        .i_points (r_x_points),
        .i_q      (i_in.data.query_x),
        .o_cell   (x_cell),
        .o_stat   (x_stat)
    );

    bgt_axis #(.DEPTH(MAX_Y_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_y_axis (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (in_xfer && i_in.data.cmd == bgt_pkg::CMD_LOAD_Y &&
                   32'(i_in.data.load_index) < MAX_Y_POINTS),
        .i_waddr  (YW'(i_in.data.load_index)),
        .i_wdata  (load_val),
        .i_start  (in_xfer && is_query),
        .i_points (r_y_points),
        .i_q      (i_in.data.query_y),
        .o_cell   (y_cell),
        .o_stat   (y_stat)
    );

    // corner order: bit 0 picks the upper x row, bit 1 the upper y column
    assign g_raddr = r_base + (r_corner[0] ? GW'(r_y_points) : GW'(0)) +
                     GW'(y_cell) + GW'(r_corner[1]);

    bgt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(GRID_DEPTH)) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_in.data.cmd == bgt_pkg::CMD_LOAD_GRID &&
                  32'(i_in.data.load_index) < GRID_DEPTH),
        .i_waddr (GW'(i_in.data.load_index)),
        .i_wdata (load_val),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    // Q1.16 weight terms of the current corner
    assign ta = r_corner[0] ? x_stat.weight : bgt_pkg::WEIGHT_ONE - x_stat.weight;
    assign tb = r_corner[1] ? y_stat.weight : bgt_pkg::WEIGHT_ONE - y_stat.weight;

    // floor by 2^32, then saturate to the value range
    assign res  = RW'(r_sum >>> 32);
    assign fits = (res[RW-1:VALUE_WIDTH-1] == '0) || (res[RW-1:VALUE_WIDTH-1] == '1);
    assign sat  = fits ? VALUE_WIDTH'(res) :
                  (res[RW-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} :
                               {1'b0, {(VALUE_WIDTH-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_x_points  <= XPW'(2);
            r_y_points  <= YPW'(2);
            r_out_valid <= 1'b0;
            r_corner    <= '0;
        end else begin
            // configuration writes, clamped to 2..max
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bgt_pkg::CFG_X_POINTS: begin
                        priority if (i_cfg_data < 7'd2) r_x_points <= XPW'(2);
                        else if (32'(i_cfg_data) > MAX_X_POINTS)
                            r_x_points <= XPW'(MAX_X_POINTS);
                        else r_x_points <= XPW'(i_cfg_data);
                    end
                    bgt_pkg::CFG_Y_POINTS: begin
                        priority if (i_cfg_data < 7'd2) r_y_points <= YPW'(2);
                        else if (32'(i_cfg_data) > MAX_Y_POINTS)
                            r_y_points <= YPW'(MAX_Y_POINTS);
                        else r_y_points <= YPW'(i_cfg_data);
                    end
                    default: ;
                endcase
            end

            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (in_xfer && is_query) begin
                        r_state <= T_AXIS;
                    end
                end
                T_AXIS: begin
                    if (x_stat.done && y_stat.done) begin
                        r_state <= T_BASE;
                    end
                end
                T_BASE: begin
                    r_base   <= GW'(x_cell * r_y_points);
                    r_corner <= '0;
                    r_sum    <= '0;
                    r_state  <= T_RD;
                end
                T_RD: begin
                    r_w     <= 33'(ta * tb);
                    r_state <= T_MUL;
                end
                T_MUL: begin
                    r_prod  <= PW'($signed({1'b0, r_w}) * g_rdata);
                    r_state <= T_ACC;
                end
                T_ACC: begin
                    r_sum    <= r_sum + SW'(r_prod);
                    r_corner <= r_corner + 2'd1;
                    r_state  <= (r_corner == 2'd3) ? T_FIN : T_RD;
                end
                T_FIN: begin
                    if (!r_out_valid || out_xfer) begin
                        r_out_valid         <= 1'b1;
                        r_out.interp_value  <= 32'(sat);
                        r_out.x_cell        <= 6'(x_cell);
                        r_out.y_cell        <= 6'(y_cell);
                        r_out.flat_interval <= x_stat.flat || y_stat.flat;
                        r_state             <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // a query transfer restarts both searches
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_query) |=> (!x_stat.done && !y_stat.done))
        else $error("axis search not restarted by query");

    // a result appears only at the end of a query
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == T_FIN))
        else $error("result register loaded outside final step");

    // the fourth corner closes the sum
    a_four_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_ACC && r_corner == 2'd3) |=> (r_state == T_FIN))
        else $error("corner sequence out of step");

    // no input is taken during the axis search or a corner read
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_AXIS || r_state == T_RD) |-> !i_in.ready)
        else $error("input ready during a query");
endmodule

/* src/bgt_ram.sv */
// bgt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module bgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/bgt_axis.sv */
// bgt_axis: one axis of the table: breakpoint ram, bisection search and
// serial weight division; uses bgt_pkg and bgt_ram
module bgt_axis #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [VALUE_WIDTH-1:0]       i_wdata,
    input  logic                         i_start,
    input  logic [$clog2(DEPTH+1)-1:0]   i_points,
    input  logic signed [31:0]           i_q,
    output logic [$clog2(DEPTH)-1:0]     o_cell,
    output bgt_pkg::t_bgt_axis_stat      o_stat
);
    localparam int IW = $clog2(DEPTH);
    localparam int EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int DW = EW + 1;

    typedef enum logic [2:0] {
        A_IDLE, A_END, A_FIRST, A_BIS, A_LOW, A_HIGH, A_DIV
    } t_astate;

    t_astate                 r_state;
    logic [IW-1:0]           r_lo, r_hi, r_mid;
    logic                    r_asc;
    logic signed [EW-1:0]    r_q;
    logic signed [VALUE_WIDTH-1:0] r_last, r_a0;
    logic [DW-1:0]           r_rem, r_den;
    logic [15:0]             r_quo;
    logic [3:0]              r_step;
    logic                    r_done, r_flat;
    logic [16:0]             r_weight;
    // the quotient stands in r_quo once a division has finished
    logic                    r_weight_from_div;

    logic [IW-1:0]           raddr;
    logic signed [VALUE_WIDTH-1:0] rdata;
    logic                    go_up;
    logic [IW-1:0]           c_lo, c_hi, c_mid;
    logic [IW:0]             c_sum;
    logic                    c_more;
    logic signed [DW-1:0]    num, den;
    logic [DW-1:0]           un, ud;
    logic [DW:0]             trial;

    bgt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // bisection step on the entry read in the previous cycle
    assign go_up  = ((EW'(r_q) >= EW'(rdata)) == r_asc);
    assign c_lo   = (r_state == A_BIS && go_up) ? r_mid : r_lo;
    assign c_hi   = (r_state == A_BIS && !go_up) ? r_mid : r_hi;
    assign c_sum  = {1'b0, c_lo} + {1'b0, c_hi};
    assign c_mid  = c_sum[IW:1];
    assign c_more = (c_hi - c_lo) > IW'(1);

    assign num   = DW'(r_q) - DW'(r_a0);
    assign den   = DW'(rdata) - DW'(r_a0);
    assign un    = num[DW-1] ? DW'(-num) : DW'(num);
    assign ud    = den[DW-1] ? DW'(-den) : DW'(den);
    assign trial = {r_rem, 1'b0};

    always_comb begin
        unique case (r_state)
            A_IDLE:           raddr = IW'(i_points - 1'b1);
            A_FIRST, A_BIS:   raddr = c_more ? c_mid : c_lo;
            A_LOW:            raddr = r_lo + IW'(1);
            default:          raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_q     <= EW'(i_q);
                        r_lo    <= '0;
                        r_hi    <= IW'(i_points - 1'b1);
                        r_done  <= 1'b0;
                        r_flat  <= 1'b0;
                        r_state <= A_END;
                    end
                end
                A_END: begin
                    r_last  <= rdata;
                    r_state <= A_FIRST;
                end
                A_FIRST, A_BIS: begin
                    if (r_state == A_FIRST) begin
                        r_asc <= (r_last >= rdata);
                    end
                    r_lo    <= c_lo;
                    r_hi    <= c_hi;
                    r_mid   <= c_mid;
                    r_state <= c_more ? A_BIS : A_LOW;
                end
                A_LOW: begin
                    r_a0    <= rdata;
                    r_state <= A_HIGH;
                end
                A_HIGH: begin
                    priority if (den == '0) begin
                        r_flat   <= 1'b1;
                        r_weight <= '0;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end else if (num == '0 || (num[DW-1] != den[DW-1])) begin
                        r_weight <= '0;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end else if (un >= ud) begin
                        r_weight <= bgt_pkg::WEIGHT_ONE;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end else begin
                        r_rem   <= un;
                        r_den   <= ud;
                        r_step  <= '0;
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= DW'(trial - {1'b0, r_den});
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= DW'(trial);
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_state <= A_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_cell        = r_lo;
    assign o_stat.done   = r_done;
    assign o_stat.flat   = r_flat;
    assign o_stat.weight = (r_state == A_IDLE && r_done && r_weight_from_div) ?
                           {1'b0, r_quo} : r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_from_div <= 1'b0;
        end else if (r_state == A_HIGH) begin
            r_weight_from_div <= !(den == '0 || num == '0 ||
                                   (num[DW-1] != den[DW-1]) || un >= ud);
        end
    end
endmodule
